[hdl/frustum_box_sphere_cull_core_assert.svh]
// assertion macros for the frustum cull core
`ifndef FRUSTUM_BOX_SPHERE_CULL_CORE_ASSERT_SVH
`define FRUSTUM_BOX_SPHERE_CULL_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define FBSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define FBSC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/fbsc_pkg.sv]
// shared types and constants for the frustum cull core
package fbsc_pkg;

    // plane storage
    localparam int MAX_PLANES  = 6;
    localparam int PLANE_REGS  = 6;
    localparam int FRAC_BITS   = 14;
    localparam int CNT_W       = 4;   // holds 0..15
    localparam int USE_W       = 3;   // width of the planes_in_use register

    // field widths
    localparam int COORD_W     = 16;
    localparam int EXT_W       = 15;
    localparam int RAD_W       = 16;
    localparam int NORM_W      = 16;
    localparam int PROD_W      = 2 * COORD_W;          // n * c
    localparam int MAG_W       = NORM_W;               // |n| up to 2^15
    localparam int PUSH_TERM_W = MAG_W + EXT_W;
    localparam int PUSH_W      = PUSH_TERM_W + 2;      // sum of three terms
    localparam int SCALED_W    = COORD_W + FRAC_BITS;  // w or radius at 2^14
    localparam int DIST_W      = PROD_W + 3;           // signed distance

    // configuration port
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 64;
    localparam logic [CFG_ADDR_W-1:0] REG_PLANE_0       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PLANES_IN_USE = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPHERE_EN     = 3'd7;
    localparam logic [USE_W-1:0]      PLANES_IN_USE_RST = 3'd6;

    // stream widths
    localparam int ITEM_W       = 3 * COORD_W + 3 * EXT_W + RAD_W;
    localparam int IN_TDATA_W   = ((ITEM_W + 7) / 8) * 8;
    localparam int RESULT_W     = 3;
    localparam int OUT_TDATA_W  = 8;

    typedef enum logic [1:0] {
        REASON_VISIBLE = 2'd0,
        REASON_SPHERE  = 2'd1,
        REASON_BOX     = 2'd2
    } reason_t;

    // one plane, nx in the low bits
    typedef struct packed {
        logic signed [NORM_W-1:0]  w;
        logic signed [NORM_W-1:0]  nz;
        logic signed [NORM_W-1:0]  ny;
        logic signed [NORM_W-1:0]  nx;
    } plane_t;

    // configuration seen by the datapath
    typedef struct packed {
        plane_t [MAX_PLANES-1:0] planes;
        logic [CNT_W-1:0]        plane_cnt;   // already limited to MAX_PLANES
        logic                    sphere_en;
    } cfg_t;

    // one input item, center_x in the low bits
    typedef struct packed {
        logic [RAD_W-1:0]          sphere_radius;
        logic [EXT_W-1:0]          extent_z;
        logic [EXT_W-1:0]          extent_y;
        logic [EXT_W-1:0]          extent_x;
        logic signed [COORD_W-1:0] center_z;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_x;
    } item_t;

    // one result, visible in the low bit
    typedef struct packed {
        reason_t reject_reason;
        logic    visible;
    } result_t;

    // per-plane test outcome
    typedef struct packed {
        logic sphere_hit;
        logic box_hit;
    } hits_t;

endpackage

[hdl/fbsc_cfg_regs.sv]
// configuration registers: view planes, plane count and sphere enable
module fbsc_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fbsc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [fbsc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output fbsc_pkg::cfg_t                    cfg
);

    fbsc_pkg::plane_t [fbsc_pkg::MAX_PLANES-1:0] planes_reg;
    logic [fbsc_pkg::USE_W-1:0]                  planes_in_use_reg;
    logic                                        sphere_en_reg;
    logic [fbsc_pkg::CNT_W-1:0]                  use_ext;

    // plane registers; planes without a register stay zero
    for (genvar i = 0; i < fbsc_pkg::MAX_PLANES; i++) begin : g_plane
        if (i < fbsc_pkg::PLANE_REGS) begin : g_wr
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    planes_reg[i] <= '0;
                end
                else if (cfg_we && (cfg_addr == fbsc_pkg::REG_PLANE_0
                                    + fbsc_pkg::CFG_ADDR_W'(i)))
                begin
                    planes_reg[i] <= cfg_wdata;
                end
            end
        end
        else begin : g_zero
            assign planes_reg[i] = '0;
        end
    end

    // scalar registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            planes_in_use_reg <= fbsc_pkg::PLANES_IN_USE_RST;
            sphere_en_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == fbsc_pkg::REG_PLANES_IN_USE)
            begin
                planes_in_use_reg <= cfg_wdata[fbsc_pkg::USE_W-1:0];
            end
            if (cfg_addr == fbsc_pkg::REG_SPHERE_EN)
            begin
                sphere_en_reg <= cfg_wdata[0];
            end
        end
    end

    // plane count limited to the planes that exist
    assign use_ext = fbsc_pkg::CNT_W'(planes_in_use_reg);

    always_comb
    begin
        cfg.planes    = planes_reg;
        cfg.sphere_en = sphere_en_reg;
        if (use_ext > fbsc_pkg::CNT_W'(fbsc_pkg::MAX_PLANES))
        begin
            cfg.plane_cnt = fbsc_pkg::CNT_W'(fbsc_pkg::MAX_PLANES);
        end
        else
        begin
            cfg.plane_cnt = use_ext;
        end
    end

endmodule

[hdl/fbsc_plane_eval.sv]
// one plane: signed distance against radius and projected box extent
module fbsc_plane_eval (
    input  fbsc_pkg::plane_t  plane,
    input  fbsc_pkg::item_t   item,
    output fbsc_pkg::hits_t   hits
);

    logic signed [fbsc_pkg::PROD_W-1:0]   px, py, pz;
    logic signed [fbsc_pkg::SCALED_W-1:0] w_scaled;
    logic signed [fbsc_pkg::DIST_W-1:0]   distance;
    logic [fbsc_pkg::MAG_W-1:0]           mx, my, mz;
    logic [fbsc_pkg::PUSH_TERM_W-1:0]     tx, ty, tz;
    logic [fbsc_pkg::PUSH_W-1:0]          push;
    logic [fbsc_pkg::SCALED_W-1:0]        rad_scaled;
    logic signed [fbsc_pkg::DIST_W-1:0]   push_cmp, rad_cmp;

    // n . c - w, all at a scale of 2^14
    assign px       = plane.nx * item.center_x;
    assign py       = plane.ny * item.center_y;
    assign pz       = plane.nz * item.center_z;
    assign w_scaled = {plane.w, {fbsc_pkg::FRAC_BITS{1'b0}}};
    assign distance = fbsc_pkg::DIST_W'(px) + fbsc_pkg::DIST_W'(py)
                    + fbsc_pkg::DIST_W'(pz) - fbsc_pkg::DIST_W'(w_scaled);

    // normal magnitudes; the most negative code gives 2^15 exactly
    assign mx = plane.nx[fbsc_pkg::NORM_W-1] ? fbsc_pkg::MAG_W'(-plane.nx)
                                             : fbsc_pkg::MAG_W'(plane.nx);
    assign my = plane.ny[fbsc_pkg::NORM_W-1] ? fbsc_pkg::MAG_W'(-plane.ny)
                                             : fbsc_pkg::MAG_W'(plane.ny);
    assign mz = plane.nz[fbsc_pkg::NORM_W-1] ? fbsc_pkg::MAG_W'(-plane.nz)
                                             : fbsc_pkg::MAG_W'(plane.nz);

    // box extent projected on the normal
    assign tx   = mx * item.extent_x;
    assign ty   = my * item.extent_y;
    assign tz   = mz * item.extent_z;
    assign push = fbsc_pkg::PUSH_W'(tx) + fbsc_pkg::PUSH_W'(ty) + fbsc_pkg::PUSH_W'(tz);

    // unsigned limits brought into the signed compare width
    assign rad_scaled = {item.sphere_radius, {fbsc_pkg::FRAC_BITS{1'b0}}};
    assign rad_cmp    = {{(fbsc_pkg::DIST_W - fbsc_pkg::SCALED_W){1'b0}}, rad_scaled};
    assign push_cmp   = {{(fbsc_pkg::DIST_W - fbsc_pkg::PUSH_W){1'b0}}, push};

    assign hits.sphere_hit = distance > rad_cmp;
    assign hits.box_hit    = distance > push_cmp;

endmodule

[hdl/frustum_box_sphere_cull_core.sv]
// top level of the frustum cull core
//
// Culls one bounding volume (box center, half extents, sphere radius) per
// transfer against up to six view planes held in configuration registers.
// Input items arrive on the s_ stream and one result per item leaves on the
// m_ stream: visible plus the reject reason (sphere test or box test).
// Planes, plane count and the sphere pre-test enable are written through
// cfg_we / cfg_addr / cfg_wdata and must only change while the core is empty.
// An accepted item passes the input register, then the result register, before
// it is offered on m_tvalid; all plane tests run in parallel between the two
// registers, one set of multipliers per plane.
// Throughput: one item per cycle while m_tready is high.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; s_tready drops only when both are full and
// m_tready is low.
// Reset clears both valid flags, zeroes all planes, sets the plane count to
// six and turns the sphere pre-test on.
`include "frustum_box_sphere_cull_core_assert.svh"

module frustum_box_sphere_cull_core (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration writes
    input  logic                               cfg_we,
    input  logic [fbsc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [fbsc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // center_x, center_y, center_z, extent_x, extent_y, extent_z, sphere_radius
    input  logic [fbsc_pkg::IN_TDATA_W-1:0]    s_tdata,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // visible, reject_reason
    output logic [fbsc_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    fbsc_pkg::cfg_t                           cfg;
    fbsc_pkg::item_t                          item_reg;
    logic                                     s1_valid_reg;
    fbsc_pkg::result_t                        result_reg;
    fbsc_pkg::result_t                        result_next;
    logic                                     m_valid_reg;
    logic                                     out_load;
    fbsc_pkg::hits_t [fbsc_pkg::MAX_PLANES-1:0] hits;
    logic [fbsc_pkg::MAX_PLANES-1:0]          plane_en;
    logic                                     sphere_rej;
    logic                                     box_rej;

    fbsc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // handshake between the two register stages
    assign out_load = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || out_load;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_tdata[fbsc_pkg::ITEM_W-1:0];
        end
    end

    // one test unit per plane
    for (genvar i = 0; i < fbsc_pkg::MAX_PLANES; i++) begin : g_plane
        fbsc_plane_eval u_eval (
            .plane (cfg.planes[i]),
            .item  (item_reg),
            .hits  (hits[i])
        );
        assign plane_en[i] = fbsc_pkg::CNT_W'(i) < cfg.plane_cnt;
    end

    // combine the planes in use
    always_comb
    begin
        sphere_rej = 1'b0;
        box_rej    = 1'b0;
        for (int i = 0; i < fbsc_pkg::MAX_PLANES; i++)
        begin
            sphere_rej = sphere_rej | (plane_en[i] & hits[i].sphere_hit);
            box_rej    = box_rej    | (plane_en[i] & hits[i].box_hit);
        end
        sphere_rej = sphere_rej & cfg.sphere_en;

        if (sphere_rej)
        begin
            result_next.reject_reason = fbsc_pkg::REASON_SPHERE;
        end
        else if (box_rej)
        begin
            result_next.reject_reason = fbsc_pkg::REASON_BOX;
        end
        else
        begin
            result_next.reject_reason = fbsc_pkg::REASON_VISIBLE;
        end
        result_next.visible = !sphere_rej && !box_rej;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(fbsc_pkg::OUT_TDATA_W - fbsc_pkg::RESULT_W){1'b0}}, result_reg};

    // checks
    `FBSC_ASSERT_IMP(a_visible_matches_reason, clk, rst_n, m_valid_reg,
        result_reg.visible == (result_reg.reject_reason == fbsc_pkg::REASON_VISIBLE),
        "visible flag disagrees with reject reason")
    `FBSC_ASSERT_IMP(a_sphere_reason_needs_enable, clk, rst_n,
        m_valid_reg && (result_reg.reject_reason == fbsc_pkg::REASON_SPHERE),
        cfg.sphere_en, "sphere rejection while the sphere test is off")
    `FBSC_ASSERT_IMP(a_full_stall_blocks_input, clk, rst_n,
        s1_valid_reg && m_valid_reg && !m_tready, !s_tready,
        "input taken while both stages are full and stalled")
    `FBSC_ASSERT_IMP(a_result_from_item, clk, rst_n, $rose(m_valid_reg),
        $past(s1_valid_reg), "result appeared without an item in the input stage")

endmodule

[bench/testbench.sv]
// self-checking stream testbench for the frustum box and sphere cull core
`timescale 1ns / 100ps

module testbench;
    import fbsc_pkg::*;

    localparam int          PHASES        = 8;
    localparam int          PHASE_ITEMS   = 175;
    localparam int          HOLD_CYCLES   = 100;
    localparam int          SETTLE_CYCLES = 4;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // one row of the directed table: a register write or an item
    typedef struct {
        bit                    is_cfg;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] data;
        item_t                 it;
        bit                    typed;
        result_t               want;
    } step_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    // center_x, center_y, center_z, extent_x, extent_y, extent_z, sphere_radius
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // visible, reject_reason
    logic [OUT_TDATA_W-1:0] m_tdata;

    // shadow copy of the configuration
    plane_t                 view_planes [MAX_PLANES];
    logic [USE_W-1:0]       planes_active;
    logic                   sphere_on;

    result_t                pending_results [$];
    step_row_t              dir_tab [$];
    int unsigned            err_cnt = 0;
    int unsigned            cycle_cnt = 0;
    int unsigned            send_idle_pct = 0;
    int unsigned            recv_stall_pct = 0;
    int unsigned            hold_left = 0;
    bit                     hold_req = 1'b0;
    result_t                mon_got;
    result_t                mon_want;

    int                     phase_use  [PHASES] = '{6, 7, 1, 3, 6, 0, 2, 6};
    bit                     phase_sph  [PHASES] = '{1, 0, 1, 1, 0, 1, 0, 1};
    idle_mode_t             phase_mode [PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER,
                                                    IDLE_BOTH, IDLE_NONE, IDLE_BOTH,
                                                    IDLE_RECEIVER, IDLE_SENDER};

    frustum_box_sphere_cull_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // cycle watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random stalls plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker, one expectation per transfer
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            mon_got = result_t'(m_tdata[RESULT_W-1:0]);
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing expected: visible %0d reject_reason %0d",
                       mon_got.visible, mon_got.reject_reason);
                err_cnt++;
            end
            else
            begin
                mon_want = pending_results.pop_front();
                if (mon_got.visible !== mon_want.visible)
                begin
                    $error("visible: expected %0d, actual %0d",
                           mon_want.visible, mon_got.visible);
                    err_cnt++;
                end
                if (mon_got.reject_reason !== mon_want.reject_reason)
                begin
                    $error("reject_reason: expected %0d, actual %0d",
                           mon_want.reject_reason, mon_got.reject_reason);
                    err_cnt++;
                end
            end
        end
    end

    function automatic result_t verdict(reason_t why);
        result_t r;
        r.reject_reason = why;
        r.visible       = (why == REASON_VISIBLE);
        return r;
    endfunction

    function automatic longint mag16(logic signed [NORM_W-1:0] v);
        longint x;
        x = longint'(v);
        return (x < 0) ? -x : x;
    endfunction

    // n.c - w at a scale of 2^14
    function automatic longint plane_dist(plane_t p, longint cx, longint cy, longint cz);
        return longint'(p.nx) * cx + longint'(p.ny) * cy + longint'(p.nz) * cz
               - longint'(p.w) * (longint'(1) <<< FRAC_BITS);
    endfunction

    // culling verdict for one item under the shadow configuration
    function automatic result_t predict_cull(item_t it);
        longint  cx, cy, cz, ex, ey, ez, rad, push;
        int      n;
        reason_t why;
        cx  = longint'(it.center_x);
        cy  = longint'(it.center_y);
        cz  = longint'(it.center_z);
        ex  = longint'(it.extent_x);
        ey  = longint'(it.extent_y);
        ez  = longint'(it.extent_z);
        rad = longint'(it.sphere_radius) * (longint'(1) <<< FRAC_BITS);
        n   = (int'(planes_active) > MAX_PLANES) ? MAX_PLANES : int'(planes_active);
        why = REASON_VISIBLE;
        // sphere pre-test
        if (sphere_on)
            for (int i = 0; i < n && why == REASON_VISIBLE; i++)
                if (plane_dist(view_planes[i], cx, cy, cz) > rad)
                    why = REASON_SPHERE;
        // box test
        if (why == REASON_VISIBLE)
            for (int i = 0; i < n && why == REASON_VISIBLE; i++)
            begin
                push = mag16(view_planes[i].nx) * ex + mag16(view_planes[i].ny) * ey
                       + mag16(view_planes[i].nz) * ez;
                if (plane_dist(view_planes[i], cx, cy, cz) > push)
                    why = REASON_BOX;
            end
        return verdict(why);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] mk_plane(int nx, int ny, int nz, int w);
        return {16'(w), 16'(nz), 16'(ny), 16'(nx)};
    endfunction

    function automatic item_t mk_item(int cx, int cy, int cz, int ex, int ey, int ez, int r);
        item_t it;
        it.center_x      = 16'(cx);
        it.center_y      = 16'(cy);
        it.center_z      = 16'(cz);
        it.extent_x      = 15'(ex);
        it.extent_y      = 15'(ey);
        it.extent_z      = 15'(ez);
        it.sphere_radius = 16'(r);
        return it;
    endfunction

    function automatic step_row_t item_row(item_t it, bit typed, reason_t why);
        step_row_t row;
        row.is_cfg = 1'b0;
        row.addr   = '0;
        row.data   = '0;
        row.it     = it;
        row.typed  = typed;
        row.want   = verdict(why);
        return row;
    endfunction

    function automatic step_row_t cfg_row(logic [CFG_ADDR_W-1:0] a, logic [CFG_DATA_W-1:0] d);
        step_row_t row;
        row.is_cfg = 1'b1;
        row.addr   = a;
        row.data   = d;
        row.it     = '0;
        row.typed  = 1'b0;
        row.want   = verdict(REASON_VISIBLE);
        return row;
    endfunction

    // mostly frustum-like planes, sometimes raw bits
    function automatic logic [CFG_DATA_W-1:0] rand_plane();
        int w;
        if ($urandom_range(3) == 0)
            return {$urandom, $urandom};
        w = ($urandom_range(1) == 0) ? int'(16'($urandom)) : int'($urandom_range(4000)) - 2000;
        return mk_plane(int'($urandom_range(32768)) - 16384, int'($urandom_range(32768)) - 16384,
                        int'($urandom_range(32768)) - 16384, w);
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        if ($urandom_range(1) == 0)
            return COORD_W'($urandom);
        return COORD_W'(int'($urandom_range(4000)) - 2000);
    endfunction

    function automatic logic [EXT_W-1:0] rand_ext();
        if ($urandom_range(1) == 0)
            return EXT_W'($urandom);
        return EXT_W'($urandom_range(500));
    endfunction

    function automatic item_t rand_item();
        item_t it;
        it.center_x      = rand_coord();
        it.center_y      = rand_coord();
        it.center_z      = rand_coord();
        it.extent_x      = rand_ext();
        it.extent_y      = rand_ext();
        it.extent_z      = rand_ext();
        it.sphere_radius = ($urandom_range(1) == 0) ? RAD_W'($urandom) : RAD_W'($urandom_range(3000));
        return it;
    endfunction

    // register write; the enable never toggles within one step
    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= d;
        @(posedge clk);
        if (a < PLANE_REGS)
            view_planes[a] = plane_t'(d);
        else if (a == REG_PLANES_IN_USE)
            planes_active = d[USE_W-1:0];
        else if (a == REG_SPHERE_EN)
            sphere_on = d[0];
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // offer one item and record its expected verdict on transfer
    task automatic send_item(input item_t it, input bit typed, input result_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(it);
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(typed ? want : predict_cull(it));
        @(negedge clk);
    endtask

    // stop offering until every expected result has arrived
    task automatic drain_wait();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // idling mode and optional long receiver hold-off, set between edges
    task automatic set_idling(input idle_mode_t mode, input bit hold);
        s_tvalid <= 1'b0;
        @(posedge clk);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 67; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default:       begin send_idle_pct = 32; recv_stall_pct = 32; end
        endcase
        if (hold)
            hold_req = 1'b1;
        @(negedge clk);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        for (int i = 0; i < MAX_PLANES; i++)
            view_planes[i] = '0;
        planes_active = PLANES_IN_USE_RST;
        sphere_on     = 1'b1;

        // directed table
        // all planes zero after reset: everything visible
        dir_tab.push_back(item_row(mk_item(32767, 32767, 32767, 32767, 32767, 32767, 65535),
                                   1'b1, REASON_VISIBLE));
        dir_tab.push_back(item_row(mk_item(-32768, -32768, -32768, 0, 0, 0, 0),
                                   1'b1, REASON_VISIBLE));
        // single plane x > 0 outside
        dir_tab.push_back(cfg_row(REG_PLANE_0, mk_plane(16384, 0, 0, 0)));
        dir_tab.push_back(cfg_row(REG_PLANES_IN_USE, 64'd1));
        dir_tab.push_back(item_row(mk_item(100, 0, 0, 0, 0, 0, 50), 1'b1, REASON_SPHERE));
        dir_tab.push_back(item_row(mk_item(100, 0, 0, 0, 0, 0, 200), 1'b1, REASON_BOX));
        // distance equal to the box push and to the radius stays visible
        dir_tab.push_back(item_row(mk_item(100, 0, 0, 100, 0, 0, 200), 1'b1, REASON_VISIBLE));
        dir_tab.push_back(item_row(mk_item(100, 0, 0, 100, 0, 0, 100), 1'b1, REASON_VISIBLE));
        // sphere pre-test off
        dir_tab.push_back(cfg_row(REG_SPHERE_EN, 64'd0));
        dir_tab.push_back(item_row(mk_item(100, 0, 0, 99, 0, 0, 0), 1'b1, REASON_BOX));
        // zero planes in use
        dir_tab.push_back(cfg_row(REG_PLANES_IN_USE, 64'd0));
        dir_tab.push_back(item_row(mk_item(32767, 0, 0, 0, 0, 0, 0), 1'b1, REASON_VISIBLE));
        // count above the plane limit saturates
        dir_tab.push_back(cfg_row(REG_PLANES_IN_USE, 64'd7));
        dir_tab.push_back(item_row(mk_item(100, 0, 0, 0, 0, 0, 0), 1'b1, REASON_BOX));
        // most negative normals and extreme planes
        dir_tab.push_back(cfg_row(CFG_ADDR_W'(REG_PLANE_0 + 5),
                                  mk_plane(-32768, -32768, -32768, -32768)));
        dir_tab.push_back(cfg_row(REG_SPHERE_EN, 64'd1));
        dir_tab.push_back(item_row(mk_item(-32768, -32768, -32768, 32767, 32767, 32767, 65535),
                                   1'b0, REASON_VISIBLE));
        dir_tab.push_back(item_row(mk_item(32767, 32767, 32767, 0, 0, 0, 0), 1'b0, REASON_VISIBLE));
        dir_tab.push_back(cfg_row(CFG_ADDR_W'(REG_PLANE_0 + 1), {CFG_DATA_W{1'b1}}));
        dir_tab.push_back(cfg_row(CFG_ADDR_W'(REG_PLANE_0 + 2),
                                  mk_plane(32767, 32767, 32767, 32767)));
        dir_tab.push_back(cfg_row(CFG_ADDR_W'(REG_PLANE_0 + 3), rand_plane()));
        dir_tab.push_back(cfg_row(CFG_ADDR_W'(REG_PLANE_0 + 4), rand_plane()));
        dir_tab.push_back(item_row(mk_item(-32768, 32767, -32768, 0, 32767, 0, 65535),
                                   1'b0, REASON_VISIBLE));
        dir_tab.push_back(item_row(mk_item(0, 0, 0, 0, 0, 0, 0), 1'b0, REASON_VISIBLE));
        dir_tab.push_back(item_row(mk_item(32767, -32768, 32767, 32767, 0, 32767, 1),
                                   1'b0, REASON_VISIBLE));
        dir_tab.push_back(item_row(mk_item(-1, -1, -1, 1, 1, 1, 65535), 1'b0, REASON_VISIBLE));

        // reset
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // walk the directed table
        foreach (dir_tab[k])
        begin
            if (dir_tab[k].is_cfg)
            begin
                drain_wait();
                cfg_write(dir_tab[k].addr, dir_tab[k].data);
            end
            else
                send_item(dir_tab[k].it, dir_tab[k].typed, dir_tab[k].want);
        end

        // random phases, each under a fresh configuration
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_wait();
            for (int p = 0; p < PLANE_REGS; p++)
                cfg_write(CFG_ADDR_W'(REG_PLANE_0 + p), rand_plane());
            cfg_write(REG_PLANES_IN_USE, CFG_DATA_W'(phase_use[ph]));
            cfg_write(REG_SPHERE_EN, CFG_DATA_W'(phase_sph[ph]));
            set_idling(phase_mode[ph], 1'b0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // long receiver hold-off while items keep coming
                if (ph == 0 && n == 40)
                    set_idling(phase_mode[ph], 1'b1);
                // sender pause until the core is empty
                if (ph == 2 && n == 90)
                    drain_wait();
                send_item(rand_item(), 1'b0, verdict(REASON_VISIBLE));
            end
        end

        // wait for the last results
        drain_wait();
        repeat (8) @(negedge clk);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
